// ===== rtl/core/dds_pkg.sv =====
`default_nettype none
package dds_pkg;

    localparam int TIME_W   = 32;
    localparam int HEIGHT_W = 18;
    localparam int MS_W     = 16;
    localparam int STAGE_W  = 3;
    localparam int STEP_W   = 3;
    localparam int PHASE_W  = 2;
    localparam int LINES_W  = 6;
    localparam int CMD_W    = 2;
    localparam int MSTATE_W = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [STAGE_W-1:0] STAGE_TEST   = 3'd0;
    localparam logic [STAGE_W-1:0] STAGE_ABORT  = 3'd1;
    localparam logic [STAGE_W-1:0] STAGE_ARM    = 3'd3;
    localparam logic [STAGE_W-1:0] STAGE_CHUTE  = 3'd4;
    localparam logic [STAGE_W-1:0] STAGE_UNFOLD = 3'd5;
    localparam logic [STAGE_W-1:0] STAGE_START  = 3'd6;
    localparam logic [STAGE_W-1:0] STAGE_SLEEP  = 3'd7;

    localparam logic [STEP_W-1:0] STEP_LWING = 3'd0;
    localparam logic [STEP_W-1:0] STEP_RWING = 3'd1;
    localparam logic [STEP_W-1:0] STEP_LSTAB = 3'd2;
    localparam logic [STEP_W-1:0] STEP_RSTAB = 3'd3;
    localparam logic [STEP_W-1:0] STEP_KEEL  = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DONE  = 3'd5;

    localparam logic [PHASE_W-1:0] PHASE_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_WAIT = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_RUN  = 2'd2;

    localparam int LINE_LSTAB = 0;
    localparam int LINE_RSTAB = 1;
    localparam int LINE_KEEL  = 2;
    localparam int LINE_LWING = 3;
    localparam int LINE_RWING = 4;
    localparam int LINE_CHUTE = 5;

    localparam logic [MSTATE_W-1:0] MASTER_READY = 3'd4;

    typedef enum logic [CMD_W-1:0] {
        CMD_TEST  = 2'd0,
        CMD_START = 2'd1,
        CMD_SLEEP = 2'd2
    } cmd_code_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPLOY_HEIGHT = 3'd0,
        REG_SURF_TIMEOUT  = 3'd1,
        REG_CHUTE_PULSE   = 3'd2,
        REG_LWING_WAIT    = 3'd3,
        REG_LWING_ON      = 3'd4,
        REG_LSTAB_ON      = 3'd5,
        REG_RSTAB_HOLD    = 3'd6
    } cfg_reg_t;

    localparam logic signed [HEIGHT_W-1:0] DEPLOY_HEIGHT_RST = 18'sd20000;
    localparam logic [MS_W-1:0] SURF_TIMEOUT_RST = 16'd5000;
    localparam logic [MS_W-1:0] CHUTE_PULSE_RST  = 16'd6000;
    localparam logic [MS_W-1:0] LWING_WAIT_RST   = 16'd2000;
    localparam logic [MS_W-1:0] LWING_ON_RST     = 16'd2000;
    localparam logic [MS_W-1:0] LSTAB_ON_RST     = 16'd400;
    localparam logic [MS_W-1:0] RSTAB_HOLD_RST   = 16'd400;

    function automatic logic deadline_reached(input logic [TIME_W-1:0] now,
                                              input logic [TIME_W-1:0] dl);
        logic [TIME_W-1:0] diff;
        diff = now - dl;
        return ~diff[TIME_W-1];
    endfunction

    function automatic logic [TIME_W-1:0] add_ms(input logic [TIME_W-1:0] now,
                                                 input logic [MS_W-1:0] ms);
        return now + {{(TIME_W-MS_W){1'b0}}, ms};
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/descent_deploy_sequencer_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake           Beat contents
// s_        in         s_valid / s_ready   one control tick
// m_        out        m_valid / m_ready   drive lines, command, stage, step, clear
// cfg_      in         cfg_valid/cfg_ready register index and write data
//
// One tick is accepted per cycle while the output is not stalled; each beat is
// held in the input register and then in the m_ output register, set by the
// single compare-and-transition pass between the two registers. Reset returns
// the sequencer state and the configuration registers to their initial values
// and clears both valid flags. A stalled output only holds the input side once
// the input register is also full.
module descent_deploy_sequencer_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [dds_pkg::TIME_W-1:0]         s_now_ms,
    input  wire logic signed [dds_pkg::HEIGHT_W-1:0] s_height_cm,
    input  wire logic [dds_pkg::MSTATE_W-1:0]       s_master_state,
    input  wire logic                               s_switch_right_wing,
    input  wire logic                               s_switch_right_stab,
    input  wire logic                               s_switch_keel,
    input  wire logic                               s_stage_write_valid,
    input  wire logic [dds_pkg::STAGE_W-1:0]        s_stage_write,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [dds_pkg::LINES_W-1:0]             m_drive_lines,
    output logic                                    m_command_valid,
    output logic [dds_pkg::CMD_W-1:0]               m_command_code,
    output logic [dds_pkg::STAGE_W-1:0]             m_stage_now,
    output logic [dds_pkg::STEP_W-1:0]              m_step_now,
    output logic                                    m_master_clear,
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [dds_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [dds_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import dds_pkg::*;

    logic signed [HEIGHT_W-1:0] deploy_height_reg;
    logic [MS_W-1:0] surf_timeout_reg, chute_pulse_reg, lwing_wait_reg;
    logic [MS_W-1:0] lwing_on_reg, lstab_on_reg, rstab_hold_reg;

    logic [STAGE_W-1:0] stage_reg, stage_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic               fresh_reg, fresh_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [TIME_W-1:0]  deadline_reg, deadline_next;
    logic [LINES_W-1:0] lines_reg, lines_next;
    logic               cmd_valid_next, clear_next;
    logic [CMD_W-1:0]   cmd_code_next;

    logic                       in_vld_reg;
    logic [TIME_W-1:0]          now_reg;
    logic signed [HEIGHT_W-1:0] height_reg;
    logic [MSTATE_W-1:0]        master_reg;
    logic                       sw_rwing_reg, sw_rstab_reg, sw_keel_reg;
    logic                       wr_valid_reg;
    logic [STAGE_W-1:0]         wr_stage_reg;

    logic out_vld_reg;
    logic advance;

    assign advance   = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready   = !in_vld_reg || advance;
    assign m_valid   = out_vld_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deploy_height_reg <= DEPLOY_HEIGHT_RST;
            surf_timeout_reg  <= SURF_TIMEOUT_RST;
            chute_pulse_reg   <= CHUTE_PULSE_RST;
            lwing_wait_reg    <= LWING_WAIT_RST;
            lwing_on_reg      <= LWING_ON_RST;
            lstab_on_reg      <= LSTAB_ON_RST;
            rstab_hold_reg    <= RSTAB_HOLD_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEPLOY_HEIGHT: deploy_height_reg <= signed'(cfg_data);
                REG_SURF_TIMEOUT:  surf_timeout_reg  <= cfg_data[MS_W-1:0];
                REG_CHUTE_PULSE:   chute_pulse_reg   <= cfg_data[MS_W-1:0];
                REG_LWING_WAIT:    lwing_wait_reg    <= cfg_data[MS_W-1:0];
                REG_LWING_ON:      lwing_on_reg      <= cfg_data[MS_W-1:0];
                REG_LSTAB_ON:      lstab_on_reg      <= cfg_data[MS_W-1:0];
                REG_RSTAB_HOLD:    rstab_hold_reg    <= cfg_data[MS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            now_reg      <= s_now_ms;
            height_reg   <= s_height_cm;
            master_reg   <= s_master_state;
            sw_rwing_reg <= s_switch_right_wing;
            sw_rstab_reg <= s_switch_right_stab;
            sw_keel_reg  <= s_switch_keel;
            wr_valid_reg <= s_stage_write_valid;
            wr_stage_reg <= s_stage_write;
        end
    end

    always_comb begin
        stage_next     = stage_reg;
        step_next      = step_reg;
        fresh_next     = fresh_reg;
        phase_next     = phase_reg;
        deadline_next  = deadline_reg;
        lines_next     = lines_reg;
        cmd_valid_next = 1'b0;
        cmd_code_next  = CMD_TEST;
        clear_next     = 1'b0;

        if (wr_valid_reg && wr_stage_reg != stage_reg) begin
            stage_next = wr_stage_reg;
            lines_next = '0;
            phase_next = PHASE_IDLE;
            fresh_next = 1'b1;
        end

        unique case (stage_next)
            STAGE_TEST: begin
                if (master_reg != MASTER_READY) begin
                    cmd_valid_next = 1'b1;
                    cmd_code_next  = CMD_TEST;
                end
            end
            STAGE_ARM: begin
                stage_next = STAGE_CHUTE;
            end
            STAGE_CHUTE: begin
                if (phase_next == PHASE_IDLE) begin
                    if (height_reg <= deploy_height_reg) begin
                        lines_next[LINE_CHUTE] = 1'b1;
                        deadline_next = add_ms(now_reg, chute_pulse_reg);
                        phase_next    = PHASE_WAIT;
                    end
                end else if (deadline_reached(now_reg, deadline_next)) begin
                    lines_next[LINE_CHUTE] = 1'b0;
                    phase_next = PHASE_IDLE;
                    fresh_next = 1'b1;
                    stage_next = STAGE_UNFOLD;
                end
            end
            STAGE_UNFOLD: begin
                unique case (step_next)
                    STEP_LWING: begin
                        if (fresh_next) begin
                            deadline_next = add_ms(now_reg, lwing_wait_reg);
                            fresh_next    = 1'b0;
                            phase_next    = PHASE_WAIT;
                        end
                        if (phase_next == PHASE_WAIT &&
                            deadline_reached(now_reg, deadline_next)) begin
                            deadline_next = add_ms(now_reg, lwing_on_reg);
                            phase_next    = PHASE_RUN;
                        end
                        if (phase_next != PHASE_WAIT) begin
                            lines_next[LINE_LWING] = 1'b1;
                            if (deadline_reached(now_reg, deadline_next)) begin
                                lines_next[LINE_LWING] = 1'b0;
                                fresh_next = 1'b1;
                                phase_next = PHASE_IDLE;
                                step_next  = step_next + STEP_W'(1);
                            end
                        end
                    end
                    STEP_RWING: begin
                        if (fresh_next) begin
                            deadline_next = add_ms(now_reg, surf_timeout_reg);
                            fresh_next    = 1'b0;
                        end
                        lines_next[LINE_RWING] = 1'b1;
                        if (!sw_rwing_reg) begin
                            lines_next[LINE_RWING] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            step_next  = step_next + STEP_W'(1);
                        end else if (deadline_reached(now_reg, deadline_next)) begin
                            lines_next[LINE_RWING] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            stage_next = STAGE_ABORT;
                        end
                    end
                    STEP_LSTAB: begin
                        if (fresh_next) begin
                            deadline_next = add_ms(now_reg, lstab_on_reg);
                            fresh_next    = 1'b0;
                        end
                        lines_next[LINE_LSTAB] = 1'b1;
                        if (deadline_reached(now_reg, deadline_next)) begin
                            lines_next[LINE_LSTAB] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            step_next  = step_next + STEP_W'(1);
                        end
                    end
                    STEP_RSTAB: begin
                        if (fresh_next) begin
                            deadline_next = add_ms(now_reg, surf_timeout_reg);
                            fresh_next    = 1'b0;
                            phase_next    = PHASE_IDLE;
                        end
                        lines_next[LINE_RSTAB] = 1'b1;
                        if (phase_next == PHASE_IDLE) begin
                            if (!sw_rstab_reg) begin
                                deadline_next = add_ms(now_reg, rstab_hold_reg);
                                phase_next    = PHASE_WAIT;
                                if (deadline_reached(now_reg, deadline_next)) begin
                                    lines_next[LINE_RSTAB] = 1'b0;
                                    fresh_next = 1'b1;
                                    phase_next = PHASE_IDLE;
                                    step_next  = step_next + STEP_W'(1);
                                end
                            end else if (deadline_reached(now_reg, deadline_next)) begin
                                lines_next[LINE_RSTAB] = 1'b0;
                                fresh_next = 1'b1;
                                phase_next = PHASE_IDLE;
                                stage_next = STAGE_ABORT;
                            end
                        end else if (deadline_reached(now_reg, deadline_next)) begin
                            lines_next[LINE_RSTAB] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            step_next  = step_next + STEP_W'(1);
                        end
                    end
                    STEP_KEEL: begin
                        if (fresh_next) begin
                            deadline_next = add_ms(now_reg, surf_timeout_reg);
                            fresh_next    = 1'b0;
                        end
                        lines_next[LINE_KEEL] = 1'b1;
                        if (!sw_keel_reg) begin
                            lines_next[LINE_KEEL] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            step_next  = step_next + STEP_W'(1);
                        end else if (deadline_reached(now_reg, deadline_next)) begin
                            lines_next[LINE_KEEL] = 1'b0;
                            fresh_next = 1'b1;
                            phase_next = PHASE_IDLE;
                            stage_next = STAGE_ABORT;
                        end
                    end
                    STEP_DONE: begin
                        stage_next = STAGE_START;
                        clear_next = 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            STAGE_START: begin
                if (master_reg != MASTER_READY) begin
                    cmd_valid_next = 1'b1;
                    cmd_code_next  = CMD_START;
                end
            end
            STAGE_SLEEP: begin
                if (master_reg != MASTER_READY) begin
                    cmd_valid_next = 1'b1;
                    cmd_code_next  = CMD_SLEEP;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg    <= STAGE_TEST;
            step_reg     <= STEP_LWING;
            fresh_reg    <= 1'b1;
            phase_reg    <= PHASE_IDLE;
            deadline_reg <= '0;
            lines_reg    <= '0;
        end else if (advance) begin
            stage_reg    <= stage_next;
            step_reg     <= step_next;
            fresh_reg    <= fresh_next;
            phase_reg    <= phase_next;
            deadline_reg <= deadline_next;
            lines_reg    <= lines_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (!out_vld_reg || m_ready) begin
            out_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_drive_lines   <= lines_next;
            m_command_valid <= cmd_valid_next;
            m_command_code  <= cmd_code_next;
            m_stage_now     <= stage_next;
            m_step_now      <= step_next;
            m_master_clear  <= clear_next;
        end
    end

`ifndef SYNTHESIS
    a_cmd_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_command_valid |->
            (m_stage_now == STAGE_TEST || m_stage_now == STAGE_START ||
             m_stage_now == STAGE_SLEEP))
        else $error("command beat outside a master-talking stage");

    a_clear_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_master_clear |-> m_stage_now == STAGE_START && !m_command_valid)
        else $error("master clear without entry to the start stage");

    a_chute_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_drive_lines[LINE_CHUTE] |-> m_stage_now == STAGE_CHUTE)
        else $error("parachute line on outside the parachute stage");

    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> step_reg <= STEP_DONE)
        else $error("unfolding step beyond the last step");
`endif

endmodule
`default_nettype wire
